// ===== src/battery_voltage_monitor_macros.svh =====
// ----------------------------------------------------------------------------
// Battery voltage monitor assertion macros
// Shared helpers for writing clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_MONITOR_MACROS_SVH
`define BATTERY_VOLTAGE_MONITOR_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define BVM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define BVM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery voltage monitor package
// Shared widths, constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int unsigned MV_W        = 13;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned ACC_W       = 28;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned PERIOD_W    = 9;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned S_TDATA_W   = 24;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [11:0]      ADC_SCALE    = 12'd3300;
    localparam int unsigned      FILTER_SHIFT = 4;
    localparam int unsigned      MV_SHIFT     = 15;
    localparam logic [ACC_W-1:0] ACC_RESET    = 28'd216265500;

    localparam logic [MV_W-1:0] CRITICAL_RESET = 13'd2900;
    localparam logic [MV_W-1:0] LOW_RESET      = 13'd3200;
    localparam logic [MV_W-1:0] FULL_RESET     = 13'd3300;

    localparam int unsigned BLINK_OFFSET = 2630;
    localparam int unsigned PERIOD_MIN   = 60;
    localparam int unsigned PERIOD_MAX   = 500;
    localparam int unsigned PERCENT_FULL = 100;

    // Quotient bits of the percentage division, one per cycle.
    localparam int unsigned DIV_STEPS = PCT_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CRITICAL = 2'd0,
        REG_LOW      = 2'd1,
        REG_FULL     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_CRITICAL = 2'd0,
        STATUS_WARNING  = 2'd1,
        STATUS_HEALTHY  = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        LED_OFF   = 2'd0,
        LED_SOLID = 2'd1,
        LED_BLINK = 2'd2
    } led_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input beat
        logic mul;       // scale the sample
        logic filt;      // filter update and millivolt value
        logic sqr;       // squares and classification
        logic scale;     // numerator times 100, division set-up
        logic div_step;  // one quotient bit
        logic finish;    // assemble result into the output register
    } bvm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } bvm_stat_t;

endpackage

// ===== src/bvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Battery voltage monitor controller
// One-hot sequencer that steps the datapath through one beat at a time.
// ----------------------------------------------------------------------------
module bvm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bvm_pkg::bvm_stat_t stat,
    output bvm_pkg::bvm_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_FILT  = 7'b0000100,
        ST_SQR   = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    localparam logic [bvm_pkg::DIV_CNT_W-1:0] DIV_LAST =
        bvm_pkg::DIV_CNT_W'(bvm_pkg::DIV_STEPS - 1);

    state_t                           state_reg, state_next;
    logic [bvm_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FILT;
            end
            ST_FILT: begin
                cmd.filt   = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR: begin
                cmd.sqr    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bvm_datapath.sv =====
// ----------------------------------------------------------------------------
// Battery voltage monitor datapath
// Threshold registers, filter, classification, iterative percentage divider,
// LED decision and the output register.
// ----------------------------------------------------------------------------
module bvm_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bvm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bvm_pkg::MV_W-1:0]             cfg_wdata,
    input  logic [bvm_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bvm_pkg::M_TDATA_W-1:0]        m_tdata,
    input  bvm_pkg::bvm_cmd_t                    cmd,
    output bvm_pkg::bvm_stat_t                   stat
);

    localparam int unsigned MV_W   = bvm_pkg::MV_W;
    localparam int unsigned ACC_W  = bvm_pkg::ACC_W;
    localparam int unsigned SQ_W   = 2 * MV_W;
    localparam int unsigned NUM_W  = SQ_W + 7;
    localparam int unsigned DVS_W  = SQ_W + bvm_pkg::DIV_STEPS - 1;
    localparam int unsigned PCT_W  = bvm_pkg::PCT_W;
    localparam int unsigned PER_W  = bvm_pkg::PERIOD_W;

    // Millivolt limits at which the blink period hits its clamps.
    localparam logic [MV_W-1:0] MV_PERIOD_LO =
        MV_W'(bvm_pkg::BLINK_OFFSET + bvm_pkg::PERIOD_MIN / 3);
    localparam logic [MV_W-1:0] MV_PERIOD_HI =
        MV_W'(bvm_pkg::BLINK_OFFSET + bvm_pkg::PERIOD_MAX / 3 + 1);

    logic [MV_W-1:0]                 crit_reg, low_reg, full_reg;
    logic [ACC_W-1:0]                acc_reg;
    logic                            blink_reg;
    logic                            ready_reg, usb_reg;
    logic [bvm_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [ACC_W-1:0]                prod_reg;
    logic [MV_W-1:0]                 mv_reg;
    logic [SQ_W-1:0]                 dd_reg, span_sq_reg;
    bvm_pkg::status_t                status_reg;
    logic                            pct_full_reg, pct_zero_reg;
    logic [NUM_W-1:0]                num_reg;
    logic [DVS_W-1:0]                dvs_reg;
    logic [PCT_W-1:0]                quo_reg;
    logic                            out_valid_reg;
    logic [bvm_pkg::M_TDATA_W-1:0]   out_data_reg;

    logic signed [ACC_W:0]           gap;
    logic signed [ACC_W:0]           step;
    logic [ACC_W-1:0]                acc_upd;
    logic [MV_W-1:0]                 d_val, span_val;
    bvm_pkg::status_t                status_now;
    logic [NUM_W-1:0]                dd_ext;
    logic [NUM_W-1:0]                dvs_ext;
    logic                            div_fit;
    logic [PCT_W-1:0]                pct_val;
    bvm_pkg::led_mode_t              led_val;
    logic                            start_val;
    logic                            blink_val;
    logic [PER_W-1:0]                off_val;
    logic [PER_W-1:0]                period_val;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crit_reg <= bvm_pkg::CRITICAL_RESET;
            low_reg  <= bvm_pkg::LOW_RESET;
            full_reg <= bvm_pkg::FULL_RESET;
        end else if (cfg_we) begin
            case (bvm_pkg::cfg_index_t'(cfg_index))
                bvm_pkg::REG_CRITICAL: crit_reg <= cfg_wdata;
                bvm_pkg::REG_LOW:      low_reg  <= cfg_wdata;
                bvm_pkg::REG_FULL:     full_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- filter
    // The step is an arithmetic shift, so it rounds towards minus infinity.
    assign gap     = $signed({1'b0, prod_reg}) - $signed({1'b0, acc_reg});
    assign step    = gap >>> bvm_pkg::FILTER_SHIFT;
    assign acc_upd = acc_reg + step[ACC_W-1:0];

    // ------------------------------------------------------ classification
    assign d_val    = mv_reg - crit_reg;
    assign span_val = full_reg - crit_reg;

    always_comb begin
        if (mv_reg <= crit_reg) begin
            status_now = bvm_pkg::STATUS_CRITICAL;
        end else if (mv_reg <= low_reg) begin
            status_now = bvm_pkg::STATUS_WARNING;
        end else if (mv_reg <= full_reg) begin
            status_now = bvm_pkg::STATUS_HEALTHY;
        end else begin
            status_now = bvm_pkg::STATUS_FULL;
        end
    end

    // ------------------------------------------------------------- divider
    // Restoring division, one quotient bit per cycle, divisor shifted right.
    assign dd_ext  = {7'd0, dd_reg};
    assign dvs_ext = {{(NUM_W - DVS_W){1'b0}}, dvs_reg};
    assign div_fit = (dvs_ext <= num_reg);

    // -------------------------------------------------------------- result
    assign off_val = PER_W'(mv_reg - MV_W'(bvm_pkg::BLINK_OFFSET));

    always_comb begin
        if (pct_full_reg) begin
            pct_val = PCT_W'(bvm_pkg::PERCENT_FULL);
        end else if (pct_zero_reg) begin
            pct_val = '0;
        end else begin
            pct_val = quo_reg;
        end

        if (mv_reg <= MV_PERIOD_LO) begin
            period_val = PER_W'(bvm_pkg::PERIOD_MIN);
        end else if (mv_reg >= MV_PERIOD_HI) begin
            period_val = PER_W'(bvm_pkg::PERIOD_MAX);
        end else begin
            period_val = (off_val << 1) + off_val;
        end

        led_val   = bvm_pkg::LED_OFF;
        start_val = 1'b0;
        blink_val = 1'b0;
        if (usb_reg || status_reg == bvm_pkg::STATUS_HEALTHY ||
            status_reg == bvm_pkg::STATUS_FULL) begin
            led_val = bvm_pkg::LED_OFF;
        end else if (status_reg == bvm_pkg::STATUS_WARNING) begin
            led_val = bvm_pkg::LED_SOLID;
        end else begin
            led_val   = bvm_pkg::LED_BLINK;
            blink_val = 1'b1;
            start_val = !blink_reg;
        end
        if (!start_val) begin
            period_val = '0;
        end
    end

    // ---------------------------------------------------------- state regs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= bvm_pkg::ACC_RESET;
            blink_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.filt && ready_reg) begin
                acc_reg <= acc_upd;
            end
            if (cmd.finish) begin
                blink_reg     <= blink_val;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------- payload regs
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_tdata[bvm_pkg::SAMPLE_W-1:0];
            usb_reg    <= s_tdata[bvm_pkg::SAMPLE_W];
            ready_reg  <= s_tuser;
        end
        if (cmd.mul) begin
            prod_reg <= ACC_W'(sample_reg) * ACC_W'(bvm_pkg::ADC_SCALE);
        end
        if (cmd.filt) begin
            mv_reg <= ready_reg ? acc_upd[ACC_W-1:bvm_pkg::MV_SHIFT] : '0;
        end
        if (cmd.sqr) begin
            dd_reg       <= SQ_W'(d_val) * SQ_W'(d_val);
            span_sq_reg  <= SQ_W'(span_val) * SQ_W'(span_val);
            status_reg   <= status_now;
            pct_full_reg <= (mv_reg >= full_reg);
            pct_zero_reg <= (mv_reg <= crit_reg);
        end
        if (cmd.scale) begin
            num_reg <= (dd_ext << 6) + (dd_ext << 5) + (dd_ext << 2);
            dvs_reg <= {span_sq_reg, {(bvm_pkg::DIV_STEPS - 1){1'b0}}};
            quo_reg <= '0;
        end
        if (cmd.div_step) begin
            if (div_fit) begin
                num_reg <= num_reg - dvs_ext;
            end
            quo_reg <= {quo_reg[PCT_W-2:0], div_fit};
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.finish) begin
            out_data_reg <= {6'd0, period_val, start_val, led_val, pct_val,
                             status_reg, mv_reg};
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

endmodule

// ===== src/battery_voltage_monitor.sv =====
// ----------------------------------------------------------------------------
// Battery voltage monitor
// Filters converter results into millivolts, grades the battery against three
// thresholds, derives a squared charge percentage and drives the LED policy.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  -------  ---------  ---------------------------------------------------
//  s_       in         one converter result per beat, with ready and USB flags
//  m_       out        one result beat per input beat
//  cfg_     in         threshold writes, taken with cfg_we high out of reset
//
// An input beat runs through capture, scaling, filter update, squares,
// numerator scaling, the bit-serial percentage divider and the output
// register load before the next beat can be taken. A result waits in the
// output register while the next beat is taken; the last step holds only
// while that register is full and m_tready is low. Reset restores
// thresholds, filter and blink flag and clears the output valid flag.
//
module battery_voltage_monitor (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port; index 0 critical_mv, 1 low_mv, 2 full_mv.
    input  logic                              cfg_we,
    input  logic [bvm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bvm_pkg::MV_W-1:0]          cfg_wdata,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: adc_sample[15:0], on_usb[16], zero padding [23:17].
    input  logic [bvm_pkg::S_TDATA_W-1:0]     s_tdata,
    // sample_ready: the beat carries a finished conversion.
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: millivolts[12:0], status[14:13], charge_percent[21:15],
    // led_mode[23:22], blink_start[24], blink_period[33:25], zeros [39:34].
    output logic [bvm_pkg::M_TDATA_W-1:0]     m_tdata
);

    bvm_pkg::bvm_cmd_t  cmd;
    bvm_pkg::bvm_stat_t stat;

    // The controller decides which step runs; it sees only the handshake and
    // whether the output register is free.
    bvm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds all registers outside the controller, including the
    // thresholds, the filter state and the output register.
    bvm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== src/bvm_checker.sv =====
// ----------------------------------------------------------------------------
// Battery voltage monitor checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_voltage_monitor_macros.svh"

module bvm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bvm_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat must hold.
    `BVM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // Blinking only starts in blink mode, and only on a critical battery.
    `BVM_ASSERT_NOW(a_start_mode, aclk, aresetn, m_tvalid && m_tdata[24], m_tdata[23:22] == bvm_pkg::LED_BLINK && m_tdata[14:13] == bvm_pkg::STATUS_CRITICAL, "blink start outside critical blink mode")

    // A period is only reported with a blink start, and then within its clamps.
    `BVM_ASSERT_NOW(a_period_zero, aclk, aresetn, m_tvalid && !m_tdata[24], m_tdata[33:25] == 9'd0, "blink period without blink start")

    `BVM_ASSERT_NOW(a_period_range, aclk, aresetn, m_tvalid && m_tdata[24], m_tdata[33:25] >= bvm_pkg::PERIOD_MIN && m_tdata[33:25] <= bvm_pkg::PERIOD_MAX, "blink period out of range")

    // A full battery is always reported at one hundred percent.
    `BVM_ASSERT_NOW(a_full_pct, aclk, aresetn, m_tvalid && m_tdata[14:13] == bvm_pkg::STATUS_FULL, m_tdata[21:15] == bvm_pkg::PERCENT_FULL, "full status without full charge")

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
